@@ hw/rtl/drd_pkg.sv @@
// ----------------------------------------------------------------------------
// Detection row decoder package
// Shared register layout, register indexes, queue status and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package drd_pkg;

	// Field widths fixed by the stream formats.
	localparam int ELEM_W  = 24;
	localparam int SCORE_W = 23;
	localparam int CLASS_W = 7;
	localparam int LEFT_W  = 13;
	localparam int SIZE_W  = 14;
	localparam int OUT_W   = 88;

	localparam logic [SCORE_W-1:0] SCORE_MAX = 23'h7FFFFF;
	localparam logic [SIZE_W-1:0]  FRAME_MAX = 14'd8192;

	// Register reset values.
	localparam logic [22:0] RST_SCORE_THRESHOLD = 23'd410;
	localparam logic [11:0] RST_PAD_LEFT        = 12'd0;
	localparam logic [11:0] RST_PAD_TOP         = 12'd0;
	localparam logic [19:0] RST_INVERSE_SCALE   = 20'd65536;
	localparam logic [13:0] RST_FRAME_WIDTH     = 14'd1920;
	localparam logic [13:0] RST_FRAME_HEIGHT    = 14'd1080;

	// Register indexes, one word apart on the configuration port.
	typedef enum logic [2:0] {
		REG_SCORE_THRESHOLD = 3'd0,
		REG_PAD_LEFT        = 3'd1,
		REG_PAD_TOP         = 3'd2,
		REG_INVERSE_SCALE   = 3'd3,
		REG_FRAME_WIDTH     = 3'd4,
		REG_FRAME_HEIGHT    = 3'd5
	} drd_reg_t;

	// Configuration registers as seen by the datapath.
	typedef struct packed {
		logic [22:0] score_threshold;
		logic [11:0] pad_left;
		logic [11:0] pad_top;
		logic [19:0] inverse_scale;
		logic [13:0] frame_width;
		logic [13:0] frame_height;
	} drd_cfg_t;

	// Job queue status.
	typedef struct packed {
		logic full;
		logic empty;
	} drd_qstat_t;

endpackage

`default_nettype wire

@@ hw/rtl/detection_row_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// Detection row decoder unit
// A result passes the stage one registers, the job queue, the product and
// result registers of the shared box multiplier and the output register.
// Throughput: one element per cycle while the job queue has room for the job.
// Reset: arst_n clears the row search, the job queue and the result valid
// flag at once and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module detection_row_decoder_unit #(
	parameter int MAX_ELEMENTS  = 128,
	parameter int FRACTION_BITS = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// Element stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // element_value
	input  wire logic        s_tlast,   // last_element
	// Result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// box_left[12:0], box_top[25:13], box_width[39:26], box_height[53:40],
	// class_index[60:54], score[83:61], zero fill above
	output logic [87:0]      m_tdata
);
	import drd_pkg::*;

	localparam int NXW = ((FRACTION_BITS + 13 > 25) ? FRACTION_BITS + 13 : 25) + 2;
	localparam int JW  = 2 * NXW + 2 * ELEM_W + CLASS_W + SCORE_W;

	drd_cfg_t   cfg_q;
	drd_reg_t   reg_idx;
	logic       wr_en;
	logic       push, pop;
	logic [JW-1:0] job, head;
	drd_qstat_t qs;

	assign pready  = 1'b1;
	assign reg_idx = drd_reg_t'(paddr[4:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.score_threshold <= RST_SCORE_THRESHOLD;
			cfg_q.pad_left        <= RST_PAD_LEFT;
			cfg_q.pad_top         <= RST_PAD_TOP;
			cfg_q.inverse_scale   <= RST_INVERSE_SCALE;
			cfg_q.frame_width     <= RST_FRAME_WIDTH;
			cfg_q.frame_height    <= RST_FRAME_HEIGHT;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SCORE_THRESHOLD: cfg_q.score_threshold <= pwdata[22:0];
				REG_PAD_LEFT:        cfg_q.pad_left        <= pwdata[11:0];
				REG_PAD_TOP:         cfg_q.pad_top         <= pwdata[11:0];
				REG_INVERSE_SCALE:   cfg_q.inverse_scale   <= pwdata[19:0];
				REG_FRAME_WIDTH:     cfg_q.frame_width     <= pwdata[13:0];
				REG_FRAME_HEIGHT:    cfg_q.frame_height    <= pwdata[13:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_idx)
			REG_SCORE_THRESHOLD: prdata = 32'(cfg_q.score_threshold);
			REG_PAD_LEFT:        prdata = 32'(cfg_q.pad_left);
			REG_PAD_TOP:         prdata = 32'(cfg_q.pad_top);
			REG_INVERSE_SCALE:   prdata = 32'(cfg_q.inverse_scale);
			REG_FRAME_WIDTH:     prdata = 32'(cfg_q.frame_width);
			REG_FRAME_HEIGHT:    prdata = 32'(cfg_q.frame_height);
			default:             prdata = '0;
		endcase
	end

	drd_front #(
		.MAX_ELEMENTS  (MAX_ELEMENTS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.push     (push),
		.job      (job),
		.qs       (qs)
	);

	drd_queue #(
		.W (JW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (job),
		.pop       (pop),
		.head      (head),
		.qs        (qs)
	);

	drd_back #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.job      (head),
		.qs       (qs),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// The front end never pushes a job into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qs.full))
		else $error("job pushed into a full queue");

	// The back end never takes a job that is not there.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qs.empty))
		else $error("job popped from an empty queue");

	// The element stream is held back only by a full queue.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> qs.full)
		else $error("element stream stalled with room in the queue");

endmodule

`default_nettype wire

@@ hw/rtl/drd_front.sv @@
// ----------------------------------------------------------------------------
// Detection row decoder front end
// Accepts row elements, runs both argmax searches and queues one box job for
// every row that passes the length and score checks.
// ----------------------------------------------------------------------------
`default_nettype none

module drd_front #(
	parameter int MAX_ELEMENTS  = 128,
	parameter int FRACTION_BITS = 12,
	localparam int NXW = ((FRACTION_BITS + 13 > 25) ? FRACTION_BITS + 13 : 25) + 2,
	localparam int JW  = 2 * NXW + 2 * 24 + 7 + 23
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire drd_pkg::drd_cfg_t    cfg,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [23:0]          s_tdata,   // element_value
	input  wire logic                 s_tlast,   // last_element
	output logic                      push,
	output logic [JW-1:0]             job,
	input  wire drd_pkg::drd_qstat_t  qs
);
	import drd_pkg::*;

	localparam int IDXW = $clog2(MAX_ELEMENTS + 1);
	localparam int XW   = (IDXW > CLASS_W) ? IDXW : CLASS_W;
	localparam int PW   = 2 * ELEM_W;

	// Input side
	logic                    accept;
	logic                    in_range;
	logic [IDXW-1:0]         count_q;
	logic signed [ELEM_W-1:0] obj_q;
	logic signed [ELEM_W-1:0] elem;

	// Stage one registers
	logic                    valid_s1;
	logic signed [ELEM_W-1:0] v_s1;
	logic [IDXW-1:0]         idx_s1;
	logic                    inr_s1;
	logic                    last_s1;
	logic signed [PW-1:0]    prod_s1;

	// Row state
	logic signed [ELEM_W-1:0] box_q [4];
	logic [SCORE_W-1:0]      pbs_q, qbs_q;
	logic [CLASS_W-1:0]      pbc_q, qbc_q;

	// Stage one logic
	logic                    fire, stall, emit;
	logic                    v_pos, p_pos, plain_hit, prod_hit;
	logic [SCORE_W-1:0]      q_sat;
	logic [XW-1:0]           cls_plain_x, cls_prod_x;
	logic [SCORE_W-1:0]      pbs_n, qbs_n, best;
	logic [CLASS_W-1:0]      pbc_n, qbc_n, best_cls;
	logic [NXW-1:0]          padx_l, padx_t;
	logic signed [NXW-1:0]   nx, ny;

	assign elem     = $signed(s_tdata);
	assign accept   = s_tvalid && s_tready;
	assign in_range = count_q < IDXW'(MAX_ELEMENTS);

	// Element counter and stage one valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (s_tlast) begin
					count_q <= '0;
				end else if (in_range) begin
					count_q <= count_q + IDXW'(1);
				end
				valid_s1 <= 1'b1;
			end else if (!stall) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Capture the element and its product with objectness.
	always_ff @(posedge clk) begin
		if (accept) begin
			v_s1    <= elem;
			idx_s1  <= count_q;
			inr_s1  <= in_range;
			last_s1 <= s_tlast;
			prod_s1 <= obj_q * elem;
			if (in_range && count_q == IDXW'(4)) begin
				obj_q <= elem;
			end
		end
	end

	// Plain search candidate.
	assign v_pos       = !v_s1[ELEM_W-1] && (|v_s1[ELEM_W-2:0]);
	assign plain_hit   = inr_s1 && (idx_s1 >= IDXW'(4)) && v_pos && (v_s1[SCORE_W-1:0] > pbs_q);
	assign cls_plain_x = XW'(idx_s1) - XW'(4);

	// Product candidate, truncated to the element format and saturated.
	assign p_pos = !prod_s1[PW-1] && (|prod_s1[PW-2:0]);
	assign q_sat = (|prod_s1[PW-2:FRACTION_BITS+SCORE_W]) ? SCORE_MAX :
		prod_s1[FRACTION_BITS+SCORE_W-1:FRACTION_BITS];
	assign prod_hit   = inr_s1 && (idx_s1 >= IDXW'(5)) && p_pos && (q_sat > qbs_q);
	assign cls_prod_x = XW'(idx_s1) - XW'(5);

	assign pbs_n = plain_hit ? v_s1[SCORE_W-1:0] : pbs_q;
	assign pbc_n = plain_hit ? cls_plain_x[CLASS_W-1:0] : pbc_q;
	assign qbs_n = prod_hit ? q_sat : qbs_q;
	assign qbc_n = prod_hit ? cls_prod_x[CLASS_W-1:0] : qbc_q;

	// The product search wins only when strictly larger.
	assign best     = (qbs_n > pbs_n) ? qbs_n : pbs_n;
	assign best_cls = (qbs_n > pbs_n) ? qbc_n : pbc_n;

	assign emit = last_s1 && (idx_s1 >= IDXW'(5)) && (best != '0) &&
		(best >= cfg.score_threshold);
	assign stall    = valid_s1 && emit && qs.full;
	assign fire     = valid_s1 && !stall;
	assign s_tready = !stall;
	assign push     = fire && emit;

	// Box offsets with the padding removed, in doubled element units.
	assign padx_l = NXW'(cfg.pad_left) << (FRACTION_BITS + 1);
	assign padx_t = NXW'(cfg.pad_top) << (FRACTION_BITS + 1);
	assign nx = (NXW'(box_q[0]) <<< 1) - NXW'(box_q[2]) - $signed(padx_l);
	assign ny = (NXW'(box_q[1]) <<< 1) - NXW'(box_q[3]) - $signed(padx_t);

	assign job = {best, best_cls, box_q[3], box_q[2], ny, nx};

	// Best scores return to zero at every row end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pbs_q <= '0;
			qbs_q <= '0;
		end else if (fire) begin
			if (last_s1) begin
				pbs_q <= '0;
				qbs_q <= '0;
			end else begin
				pbs_q <= pbs_n;
				qbs_q <= qbs_n;
			end
		end
	end

	// Classes and box fields only matter once a score or index makes them valid.
	always_ff @(posedge clk) begin
		if (fire) begin
			pbc_q <= pbc_n;
			qbc_q <= qbc_n;
			if (inr_s1 && idx_s1 < IDXW'(4)) begin
				box_q[idx_s1[1:0]] <= v_s1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/drd_queue.sv @@
// ----------------------------------------------------------------------------
// Detection row decoder job queue
// Two-entry queue between the row search and the box arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module drd_queue #(
	parameter int W = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire logic [W-1:0]        push_data,
	input  wire logic                pop,
	output logic [W-1:0]             head,
	output drd_pkg::drd_qstat_t      qs
);
	import drd_pkg::*;

	logic [W-1:0] mem_q [2];
	logic         wr_q, rd_q;
	logic [1:0]   cnt_q;

	assign head     = mem_q[rd_q];
	assign qs.full  = (cnt_q == 2'd2);
	assign qs.empty = (cnt_q == 2'd0);

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/drd_back.sv @@
// ----------------------------------------------------------------------------
// Detection row decoder back end
// Undoes the letterbox with one shared multiplier, rounds, clamps to the frame
// and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module drd_back #(
	parameter int FRACTION_BITS = 12,
	localparam int NXW = ((FRACTION_BITS + 13 > 25) ? FRACTION_BITS + 13 : 25) + 2,
	localparam int JW  = 2 * NXW + 2 * 24 + 7 + 23
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire drd_pkg::drd_cfg_t    cfg,
	input  wire logic [JW-1:0]        job,
	input  wire drd_pkg::drd_qstat_t  qs,
	output logic                      pop,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// box_left[12:0], box_top[25:13], box_width[39:26], box_height[53:40],
	// class_index[60:54], score[83:61], zero fill above
	output logic [87:0]               m_tdata
);
	import drd_pkg::*;

	localparam int PW = NXW + 21;
	localparam int RW = PW - FRACTION_BITS - 16;
	localparam logic signed [PW:0] HALF    = (PW + 1)'(1) <<< (FRACTION_BITS + 16);
	localparam logic signed [PW:0] HALF_M1 = HALF - (PW + 1)'(1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MULT = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t                 state_q;
	logic [2:0]             k_q;
	logic [2:0]             km1;
	logic                   out_valid_q;
	logic                   out_free;

	logic signed [NXW-1:0]  j_nx, j_ny, op;
	logic signed [ELEM_W-1:0] j_w, j_h;
	logic [CLASS_W-1:0]     j_cls, cls_q;
	logic [SCORE_W-1:0]     j_best, best_q;

	logic signed [PW-1:0]   prod_q;
	logic signed [PW:0]     rsum, rshift;
	logic signed [RW-1:0]   res_q [4];
	logic [LEFT_W-1:0]      left_q, top_q, left_n, top_n;
	logic [SIZE_W-1:0]      bw_n, bh_n, span_w, span_h;
	logic [SIZE_W-1:0]      fw, fh;
	logic [LEFT_W-1:0]      fwm1, fhm1;
	logic [OUT_W-1:0]       out_q;

	assign j_nx   = $signed(job[NXW-1:0]);
	assign j_ny   = $signed(job[2*NXW-1:NXW]);
	assign j_w    = $signed(job[2*NXW+23:2*NXW]);
	assign j_h    = $signed(job[2*NXW+47:2*NXW+24]);
	assign j_cls  = job[2*NXW+54:2*NXW+48];
	assign j_best = job[2*NXW+77:2*NXW+55];

	// Multiplier operand; sizes are doubled so every product shares one shift.
	always_comb begin
		case (k_q)
			3'd0:    op = j_nx;
			3'd1:    op = j_ny;
			3'd2:    op = NXW'(j_w) <<< 1;
			3'd3:    op = NXW'(j_h) <<< 1;
			default: op = '0;
		endcase
	end

	// Round half away from zero on the registered product.
	assign rsum   = (PW + 1)'(prod_q) + (prod_q[PW-1] ? HALF_M1 : HALF);
	assign rshift = rsum >>> (FRACTION_BITS + 17);
	assign km1    = k_q - 3'd1;

	// Frame size taken saturated to its legal range.
	assign fw   = (cfg.frame_width == '0) ? SIZE_W'(1) :
		((cfg.frame_width > FRAME_MAX) ? FRAME_MAX : cfg.frame_width);
	assign fh   = (cfg.frame_height == '0) ? SIZE_W'(1) :
		((cfg.frame_height > FRAME_MAX) ? FRAME_MAX : cfg.frame_height);
	assign fwm1 = LEFT_W'(fw - SIZE_W'(1));
	assign fhm1 = LEFT_W'(fh - SIZE_W'(1));

	// Corner clamps to the frame.
	always_comb begin
		if (res_q[0][RW-1]) begin
			left_n = '0;
		end else if (res_q[0] > $signed(RW'(fwm1))) begin
			left_n = fwm1;
		end else begin
			left_n = res_q[0][LEFT_W-1:0];
		end
		if (res_q[1][RW-1]) begin
			top_n = '0;
		end else if (res_q[1] > $signed(RW'(fhm1))) begin
			top_n = fhm1;
		end else begin
			top_n = res_q[1][LEFT_W-1:0];
		end
	end

	// Size clamps, at least one pixel and no further than the frame edge.
	assign span_w = fw - SIZE_W'(left_q);
	assign span_h = fh - SIZE_W'(top_q);
	always_comb begin
		if (res_q[2][RW-1] || res_q[2] == '0) begin
			bw_n = SIZE_W'(1);
		end else if (res_q[2] > $signed(RW'(span_w))) begin
			bw_n = span_w;
		end else begin
			bw_n = res_q[2][SIZE_W-1:0];
		end
		if (res_q[3][RW-1] || res_q[3] == '0) begin
			bh_n = SIZE_W'(1);
		end else if (res_q[3] > $signed(RW'(span_h))) begin
			bh_n = span_h;
		end else begin
			bh_n = res_q[3][SIZE_W-1:0];
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign pop      = (state_q == ST_MULT) && (k_q == 3'd4);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// Sequencer: four products, then the size clamp and the result transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!qs.empty) begin
						state_q <= ST_MULT;
						k_q     <= '0;
					end
				end
				ST_MULT: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd4) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						k_q         <= '0;
						state_q     <= qs.empty ? ST_IDLE : ST_MULT;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_MULT) begin
			prod_q <= op * $signed({1'b0, cfg.inverse_scale});
			if (k_q != 3'd0) begin
				res_q[km1[1:0]] <= rshift[RW-1:0];
			end
			if (k_q == 3'd4) begin
				left_q <= left_n;
				top_q  <= top_n;
				cls_q  <= j_cls;
				best_q <= j_best;
			end
		end
		if (state_q == ST_FIN && out_free) begin
			out_q <= {4'b0, best_q, cls_q, bh_n, bw_n, top_q, left_q};
		end
	end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Detection row decoder unit testbench
// Streams detector rows through the unit and checks every box against an
// in-bench decoder that mirrors the row search, the letterbox undo and the
// frame clamp, or against a typed box. A short table of hand-picked rows
// comes first, then random rows under six register settings, with random
// idling on both streams, one long receiver hold-off and a final stretch
// with no idling. Register writes are read back over the configuration port.
// ----------------------------------------------------------------------------

module testbench;

	import drd_pkg::*;

	localparam int MAX_ELEMENTS  = 128;
	localparam int FRACTION_BITS = 12;
	localparam int DIRECTED_ROWS = 26;
	localparam int PHASE_ITEMS   = 275;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 20;
	localparam int CYCLE_LIMIT   = 300000;

	// One emitted box as the result stream carries it.
	typedef struct packed {
		logic [12:0] box_left;
		logic [12:0] box_top;
		logic [13:0] box_width;
		logic [13:0] box_height;
		logic [6:0]  class_index;
		logic [22:0] score;
	} detection_t;

	// Where the expectation of a table entry comes from.
	typedef enum logic [1:0] {
		FROM_PREDICTOR,
		TYPED_NONE,
		TYPED_BOX
	} expect_mode_t;

	typedef struct packed {
		logic [23:0]  value;
		logic         last;
		expect_mode_t mode;
		detection_t   box;
	} stimulus_row_t;

	localparam detection_t NO_DET = '0;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // element_value
	logic        s_tlast;   // last_element
	logic        m_tvalid;
	logic        m_tready;
	// box_left[12:0], box_top[25:13], box_width[39:26], box_height[53:40],
	// class_index[60:54], score[83:61], zero fill above
	logic [87:0] m_tdata;

	// Mirror of the configuration registers and the row search.
	drd_cfg_t           cfg_mirror;
	int unsigned        row_count;
	logic signed [23:0] row_box [4];
	logic signed [23:0] row_objectness;
	logic [22:0]        plain_score;
	logic [6:0]         plain_class;
	logic [22:0]        product_score;
	logic [6:0]         product_class;

	detection_t    expected_detections [$];
	detection_t    result_due;
	stimulus_row_t directed_table [DIRECTED_ROWS];
	int            error_count = 0;
	int            items_sent = 0;
	int            hold_requests = 0;
	int            watchdog_cycles;
	bit            no_idle = 1'b0;

	detection_row_decoder_unit #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.FRACTION_BITS(FRACTION_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Return the row search to its empty state.
	function automatic void clear_row_search();
		row_count = 0;
		for (int i = 0; i < 4; i++)
			row_box[i] = '0;
		row_objectness = '0;
		plain_score = '0;
		plain_class = '0;
		product_score = '0;
		product_class = '0;
	endfunction

	// Division by 2^s, rounded half away from zero.
	function automatic longint round_half_away(input longint n, input int s);
		longint m;
		m = (n < 0) ? -n : n;
		m = (m + (longint'(1) << (s - 1))) >>> s;
		return (n < 0) ? -m : m;
	endfunction

	// Frame sizes outside 1..8192 are taken saturated.
	function automatic longint frame_limit(input logic [13:0] v);
		if (v == 0)
			return 1;
		if (v > FRAME_MAX)
			return longint'(FRAME_MAX);
		return longint'(v);
	endfunction

	// Advance the row search by one element; returns 1 when a box is due.
	function automatic bit decode_element(input logic signed [23:0] value, input bit last,
			output detection_t det);
		longint v, p, q, fw, fh, nx, ny, left, top, bw, bh;
		logic [22:0] best;
		logic [6:0] cls;
		bit hit;
		v = value;
		det = NO_DET;
		hit = 1'b0;
		// Elements past the row capacity are dropped.
		if (row_count < MAX_ELEMENTS) begin
			if (row_count < 4)
				row_box[row_count] = value;
			if (row_count >= 4 && v > 0 && v > longint'(plain_score)) begin
				plain_score = 23'(v);
				plain_class = 7'(row_count - 4);
			end
			if (row_count == 4)
				row_objectness = value;
			if (row_count >= 5) begin
				p = longint'(row_objectness) * v;
				if (p > 0) begin
					q = p >>> FRACTION_BITS;
					if (q > longint'(SCORE_MAX))
						q = longint'(SCORE_MAX);
					if (q > longint'(product_score)) begin
						product_score = 23'(q);
						product_class = 7'(row_count - 5);
					end
				end
			end
			row_count++;
		end
		if (last) begin
			// The product search has to be strictly better to win.
			best = plain_score;
			cls = plain_class;
			if (product_score > plain_score) begin
				best = product_score;
				cls = product_class;
			end
			if (row_count >= 6 && best != 0 && best >= cfg_mirror.score_threshold) begin
				fw = frame_limit(cfg_mirror.frame_width);
				fh = frame_limit(cfg_mirror.frame_height);
				nx = 2 * longint'(row_box[0]) - longint'(row_box[2])
					- (longint'(cfg_mirror.pad_left) << (FRACTION_BITS + 1));
				ny = 2 * longint'(row_box[1]) - longint'(row_box[3])
					- (longint'(cfg_mirror.pad_top) << (FRACTION_BITS + 1));
				left = round_half_away(nx * longint'(cfg_mirror.inverse_scale),
					FRACTION_BITS + 17);
				top = round_half_away(ny * longint'(cfg_mirror.inverse_scale),
					FRACTION_BITS + 17);
				bw = round_half_away(longint'(row_box[2]) * longint'(cfg_mirror.inverse_scale),
					FRACTION_BITS + 16);
				bh = round_half_away(longint'(row_box[3]) * longint'(cfg_mirror.inverse_scale),
					FRACTION_BITS + 16);
				if (left < 0) left = 0;
				if (left > fw - 1) left = fw - 1;
				if (top < 0) top = 0;
				if (top > fh - 1) top = fh - 1;
				if (bw < 1) bw = 1;
				if (bw > fw - left) bw = fw - left;
				if (bh < 1) bh = 1;
				if (bh > fh - top) bh = fh - top;
				det.box_left = 13'(left);
				det.box_top = 13'(top);
				det.box_width = 14'(bw);
				det.box_height = 14'(bh);
				det.class_index = cls;
				det.score = best;
				hit = 1'b1;
			end
			clear_row_search();
		end
		return hit;
	endfunction

	// Random element, shaped by its position in the row.
	function automatic logic [23:0] random_element(input int idx);
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return 24'($urandom);
		if (pick == 1)
			return ($urandom_range(0, 1) == 1) ? 24'h7FFFFF : 24'h800000;
		if (idx < 2)
			return 24'($urandom_range(0, 2700000));
		if (idx < 4)
			return 24'($urandom_range(0, 1300000));
		case (pick)
			2: return 24'(-$urandom_range(1, 8192));
			3: return 24'd0;
			4: return 24'd4096;
			5: return 24'($urandom_range(4096, 8388607));
			default: return 24'($urandom_range(0, 4096));
		endcase
	endfunction

	// Offer one element, wait for its transfer and queue what it produces.
	task automatic send_element(input logic [23:0] value, input bit last,
			input expect_mode_t mode, input detection_t typed_box);
		detection_t det;
		bit hit;
		@(negedge clk);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		hit = decode_element(value, last, det);
		case (mode)
			TYPED_NONE: hit = 1'b0;
			TYPED_BOX: begin
				hit = 1'b1;
				det = typed_box;
			end
			default: ;
		endcase
		if (hit)
			expected_detections.push_back(det);
		items_sent++;
	endtask

	// Random rows until the item budget of a phase is spent.
	task automatic run_random_items(input int count);
		int start, len, pick;
		start = items_sent;
		while (items_sent - start < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				len = $urandom_range(1, 5);
			else if (pick < 10)
				len = $urandom_range(126, 134);
			else if (pick < 25)
				len = $urandom_range(13, 40);
			else
				len = $urandom_range(6, 12);
			for (int i = 0; i < len; i++)
				send_element(random_element(i), i == len - 1, FROM_PREDICTOR, NO_DET);
		end
	endtask

	// Stop offering and let every outstanding box come out.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_detections.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write followed by a read back of the same address.
	task automatic write_register(input drd_reg_t index, input logic [31:0] value);
		logic [31:0] stored;
		stored = '0;
		case (index)
			REG_SCORE_THRESHOLD: begin
				cfg_mirror.score_threshold = value[22:0];
				stored[22:0] = value[22:0];
			end
			REG_PAD_LEFT: begin
				cfg_mirror.pad_left = value[11:0];
				stored[11:0] = value[11:0];
			end
			REG_PAD_TOP: begin
				cfg_mirror.pad_top = value[11:0];
				stored[11:0] = value[11:0];
			end
			REG_INVERSE_SCALE: begin
				cfg_mirror.inverse_scale = value[19:0];
				stored[19:0] = value[19:0];
			end
			REG_FRAME_WIDTH: begin
				cfg_mirror.frame_width = value[13:0];
				stored[13:0] = value[13:0];
			end
			default: begin
				cfg_mirror.frame_height = value[13:0];
				stored[13:0] = value[13:0];
			end
		endcase
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== stored) begin
			$display("%0t: register %s read back expected %h actual %h",
				$time, index.name(), stored, prdata);
			error_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(input logic [31:0] threshold, input logic [31:0] pad_x,
			input logic [31:0] pad_y, input logic [31:0] inverse,
			input logic [31:0] frame_x, input logic [31:0] frame_y);
		write_register(REG_SCORE_THRESHOLD, threshold);
		write_register(REG_PAD_LEFT, pad_x);
		write_register(REG_PAD_TOP, pad_y);
		write_register(REG_INVERSE_SCALE, inverse);
		write_register(REG_FRAME_WIDTH, frame_x);
		write_register(REG_FRAME_HEIGHT, frame_y);
	endtask

	task automatic compare_field(input string name, input longint expected,
			input longint actual);
		if (expected != actual) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, expected, actual);
			error_count++;
		end
	endtask

	// Result stream checker: each transfer against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_detections.size() == 0) begin
				$display("%0t: result transfer with nothing expected, expected none actual %h",
					$time, m_tdata);
				error_count++;
			end else begin
				result_due = expected_detections.pop_front();
				compare_field("box_left", result_due.box_left, m_tdata[12:0]);
				compare_field("box_top", result_due.box_top, m_tdata[25:13]);
				compare_field("box_width", result_due.box_width, m_tdata[39:26]);
				compare_field("box_height", result_due.box_height, m_tdata[53:40]);
				compare_field("class_index", result_due.class_index, m_tdata[60:54]);
				compare_field("score", result_due.score, m_tdata[83:61]);
				compare_field("zero fill", 0, m_tdata[87:84]);
			end
		end
	end

	// Result receiver: short random stalls, and a long hold-off on request.
	initial begin : result_sink
		int holds_served;
		int hold_count;
		holds_served = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests > holds_served) begin
				m_tready <= 1'b0;
				for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
					@(negedge clk);
				holds_served++;
			end else if (!no_idle && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog.
	initial begin : watchdog
		for (watchdog_cycles = 0; watchdog_cycles < CYCLE_LIMIT; watchdog_cycles++)
			@(posedge clk);
		$display("testbench: done, errors");
		$finish;
	end

	// Stimulus sequence.
	initial begin : stimulus
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_mirror.score_threshold = RST_SCORE_THRESHOLD;
		cfg_mirror.pad_left = RST_PAD_LEFT;
		cfg_mirror.pad_top = RST_PAD_TOP;
		cfg_mirror.inverse_scale = RST_INVERSE_SCALE;
		cfg_mirror.frame_width = RST_FRAME_WIDTH;
		cfg_mirror.frame_height = RST_FRAME_HEIGHT;
		clear_row_search();

		// Plain box at the reset settings: 100,50 center, 20x10 size.
		directed_table[0]  = '{24'd409600, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[1]  = '{24'd204800, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[2]  = '{24'd81920, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[3]  = '{24'd40960, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[4]  = '{24'd4096, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[5]  = '{24'd2048, 1'b1, TYPED_BOX,
			'{13'd90, 13'd45, 14'd20, 14'd10, 7'd0, 23'd4096}};
		// Short row emits nothing.
		directed_table[6]  = '{24'd12345, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[7]  = '{24'd4096, 1'b1, TYPED_NONE, NO_DET};
		// Negative scores lose the plain search, but their product is positive.
		directed_table[8]  = '{24'd0, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[9]  = '{24'd0, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[10] = '{24'd0, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[11] = '{24'd0, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[12] = '{24'hFFF000, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[13] = '{24'hFFE000, 1'b1, TYPED_BOX,
			'{13'd0, 13'd0, 14'd1, 14'd1, 7'd0, 23'd8192}};
		// Extreme coordinates and a saturating product.
		directed_table[14] = '{24'h800000, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[15] = '{24'h7FFFFF, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[16] = '{24'h7FFFFF, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[17] = '{24'h800000, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[18] = '{24'h7FFFFF, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[19] = '{24'h7FFFFF, 1'b1, FROM_PREDICTOR, NO_DET};
		// Equal plain and product scores: the plain search keeps its class.
		directed_table[20] = '{24'd0, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[21] = '{24'd0, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[22] = '{24'd0, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[23] = '{24'd0, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[24] = '{24'd4096, 1'b0, FROM_PREDICTOR, NO_DET};
		directed_table[25] = '{24'd8192, 1'b1, TYPED_BOX,
			'{13'd0, 13'd0, 14'd1, 14'd1, 7'd1, 23'd8192}};

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < DIRECTED_ROWS; k++)
			send_element(directed_table[k].value, directed_table[k].last,
				directed_table[k].mode, directed_table[k].box);
		drain_results();

		// Reset settings, starting with a long receiver hold-off.
		hold_requests++;
		run_random_items(PHASE_ITEMS);
		drain_results();

		// Lowest threshold, largest left padding and scale, largest frame.
		configure(0, 4095, 0, 1048575, 8192, 8192);
		run_random_items(PHASE_ITEMS);
		drain_results();

		// Highest threshold, smallest scale and frame.
		configure(8388607, 0, 4095, 1, 1, 1);
		run_random_items(PHASE_ITEMS);
		drain_results();

		// Zero scale and frame sizes outside the legal range.
		configure($urandom_range(0, 4096), $urandom_range(0, 4095), $urandom_range(0, 4095),
			0, 0, 16383);
		run_random_items(PHASE_ITEMS);
		drain_results();

		// Random register words, upper bits included.
		configure($urandom_range(0, 8192), $urandom, $urandom, $urandom, $urandom, $urandom);
		run_random_items(PHASE_ITEMS);
		drain_results();

		// Typical letterbox settings with both streams running flat out.
		no_idle = 1'b1;
		configure(410, $urandom_range(0, 64), $urandom_range(0, 64),
			$urandom_range(32768, 131072), 1920, 1080);
		run_random_items(PHASE_ITEMS);
		drain_results();

		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/drd_pkg.sv
hw/rtl/drd_front.sv
hw/rtl/drd_queue.sv
hw/rtl/drd_back.sv
hw/rtl/detection_row_decoder_unit.sv
tb/testbench.sv
